// File: hw/rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and codes for the timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;
    typedef enum logic [2:0] {
        OP_TICK = 3'd0, OP_CREATE = 3'd1, OP_DELETE = 3'd2, OP_START = 3'd3,
        OP_STOP = 3'd4, OP_RESET = 3'd5, OP_CHPER = 3'd6, OP_QUERY = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;
    localparam logic [1:0] ST_NOFREE   = 2'd3;

    localparam logic [1:0] RS_STOPPED = 2'd0;
    localparam logic [1:0] RS_RUNNING = 2'd1;
    localparam logic [1:0] RS_EXPIRED = 2'd2;

    localparam int MAX_REPORTS = 16;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_CLOSE} t_state;

    // one timer's stored state
    typedef struct packed {
        logic        active;
        logic        periodic;
        logic [1:0]  run;
        logic [31:0] period;
        logic [31:0] remain;
    } t_timer;
endpackage

// File: hw/rtl/stb_cell.sv
// ----------------------------------------------------------------------------
// stb_cell
// One timer of the ring; shifts to its neighbor when the ring rotates.
// ----------------------------------------------------------------------------
module stb_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  stb_pkg::t_timer i_timer,
    output stb_pkg::t_timer o_timer
);
    import stb_pkg::*;
    t_timer r_timer;

    // the whole timer resets to zero; payload does not matter while inactive
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
        end else if (i_shift) begin
            r_timer <= i_timer;
        end
    end
    assign o_timer = r_timer;
endmodule

// File: hw/rtl/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of countdown timers held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Timers sit in a ring of NUM_TIMERS cells, and every item turns the ring once
// completely, one timer per cycle past the head cell's update logic, so each
// turn starts at timer 0: create takes the lowest free slot and a tick reports
// expirations in slot order. Each item walks the whole ring, then takes a
// closing step that loads the final result and returns to idle; the next
// item is accepted only in idle. A command's single result is the one loaded
// in the closing step. A tick loads each expiration result into the output
// register as its timer passes the head, then a closing result with last set.
// The walk and the closing step pause while a result waits on a stalled output.
// tick_enable sits at register address 0.
module software_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_period,
    input  logic        i_periodic,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot_out,
    output logic        o_expired,
    output logic [1:0]  o_run_state,
    output logic [31:0] o_remaining,
    output logic [31:0] o_tick_count,
    output logic [31:0] o_expiration_count,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stb_pkg::*;
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    // configuration
    logic r_tick_en;
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {31'd0, r_tick_en} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tick_en <= 1'b0;
        else if (psel && penable && pwrite && paddr == 1'b0) r_tick_en <= pwdata[0];
    end

    // ring: cell k holds timer (r_base + k) mod NUM_TIMERS
    t_timer c_q [NUM_TIMERS];
    t_timer head_new;
    logic   shift;
    logic [IW-1:0] r_base;
    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
            t_timer din;
            if (g == NUM_TIMERS - 1) begin : g_tail
                assign din = head_new;
            end else begin : g_mid
                assign din = c_q[g+1];
            end
            stb_cell u_cell (.i_clk, .i_rst_n, .i_shift(shift), .i_timer(din),
                             .o_timer(c_q[g]));
        end
    endgenerate

    t_state r_state, n_state;
    t_op    r_op;
    logic [3:0]  r_slot;
    logic [31:0] r_period;
    logic        r_periodic;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [4:0]  r_nrep, n_nrep;
    logic [31:0] r_ticks, n_ticks, r_exps, n_exps;
    logic [IW-1:0] n_base;
    logic          r_ovld, n_ovld;
    logic [1:0]  r_st, n_st;
    logic [3:0]  r_so, n_so;
    logic        r_ex, n_ex, r_ls, n_ls;
    logic [1:0]  r_rs, n_rs;
    logic [31:0] r_rm, n_rm;
    logic        r_pend, n_pend;

    t_timer h;
    assign h = c_q[0];
    logic out_free;
    assign out_free = !r_ovld || !i_stall;
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_base <= '0; r_ovld <= 1'b0;
            r_ticks <= '0; r_exps <= '0; r_cnt <= '0; r_nrep <= '0; r_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_base <= n_base; r_ovld <= n_ovld;
            r_ticks <= n_ticks; r_exps <= n_exps; r_cnt <= n_cnt; r_nrep <= n_nrep;
            r_pend <= n_pend;
        end
    end
    always_ff @(posedge i_clk) begin
        r_st <= n_st; r_so <= n_so; r_ex <= n_ex; r_ls <= n_ls; r_rs <= n_rs; r_rm <= n_rm;
        if (i_valid && !o_stall) begin
            r_op <= t_op'(i_op); r_slot <= i_slot; r_period <= i_period;
            r_periodic <= i_periodic;
        end
    end

    // sequencer and head-cell update
    always_comb begin
        logic        tgt;
        t_timer      t;
        n_state = r_state; n_base = r_base; n_cnt = r_cnt; n_nrep = r_nrep;
        n_ticks = r_ticks; n_exps = r_exps; n_pend = r_pend;
        n_ovld = r_ovld && i_stall;
        n_st = r_st; n_so = r_so; n_ex = r_ex; n_ls = r_ls; n_rs = r_rs; n_rm = r_rm;
        shift = 1'b0; head_new = h; t = h;
        tgt = (32'(r_base) == 32'(r_slot));
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_WALK; n_cnt = '0; n_nrep = '0; n_pend = 1'b0;
                end
            end
            S_WALK: begin
                // rotate one timer per cycle past the head; hold while a result waits
                if (out_free) begin
                    shift = 1'b1;
                    n_base = (r_base == IW'(NUM_TIMERS - 1)) ? '0 : r_base + IW'(1);
                    n_cnt = r_cnt + CW'(1);
                    if (r_cnt == '0) begin
                        n_st = ST_OK; n_so = '0; n_ex = 1'b0; n_ls = 1'b1;
                        n_rs = RS_STOPPED; n_rm = '0;
                        if (r_op == OP_TICK && r_tick_en) n_ticks = r_ticks + 32'd1;
                    end
                    if (r_op == OP_TICK) begin
                        if (r_tick_en && h.active && h.run == RS_RUNNING && h.remain != 0) begin
                            t.remain = h.remain - 32'd1;
                            if (t.remain == 0) begin
                                n_exps = r_exps + 32'd1;
                                if (h.periodic) t.remain = h.period;
                                else t.run = RS_EXPIRED;
                                // expiration result goes straight to the output
                                if (r_nrep < 5'(MAX_REPORTS)) begin
                                    n_nrep = r_nrep + 5'd1; n_ovld = 1'b1;
                                    n_st = ST_OK; n_so = 4'(r_base); n_ex = 1'b1;
                                    n_ls = 1'b0; n_rs = RS_STOPPED; n_rm = '0;
                                end
                            end
                        end
                    end else if (r_op == OP_CREATE) begin
                        if (r_period == 0) begin
                            n_st = ST_INVALID; n_pend = 1'b1;
                        end else if (!r_pend && !h.active) begin
                            t.active = 1'b1; t.periodic = r_periodic; t.run = RS_STOPPED;
                            t.period = r_period; t.remain = r_period;
                            n_so = 4'(r_base); n_pend = 1'b1;
                        end else if (!r_pend && r_cnt == CW'(NUM_TIMERS - 1)) begin
                            n_st = ST_NOFREE;
                        end
                    end else if ({28'd0, r_slot} >= 32'(NUM_TIMERS) ||
                                 (r_op == OP_CHPER && r_period == 0)) begin
                        n_st = ST_INVALID; n_so = r_slot; n_pend = 1'b1;
                    end else if (tgt && !r_pend) begin
                        n_so = r_slot; n_pend = 1'b1;
                        if (!h.active) begin
                            n_st = ST_INACTIVE;
                        end else begin
                            case (r_op)
                                OP_DELETE: begin t.active = 1'b0; t.run = RS_STOPPED; end
                                OP_START, OP_RESET: begin
                                    t.run = RS_RUNNING; t.remain = h.period;
                                end
                                OP_STOP: t.run = RS_STOPPED;
                                OP_CHPER: begin
                                    t.period = r_period;
                                    if (h.run == RS_RUNNING) t.remain = r_period;
                                end
                                OP_QUERY: begin n_rs = h.run; n_rm = h.remain; end
                                default: ;
                            endcase
                        end
                    end
                    head_new = t;
                    if (r_cnt == CW'(NUM_TIMERS - 1)) n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (out_free) begin
                    if (r_op == OP_TICK) begin
                        n_st = ST_OK; n_so = '0; n_ex = 1'b0; n_ls = 1'b1;
                        n_rs = RS_STOPPED; n_rm = '0;
                    end
                    n_ovld = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_ovld;
    assign o_status = r_st;
    assign o_slot_out = r_so;
    assign o_expired = r_ex;
    assign o_run_state = r_rs;
    assign o_remaining = r_rm;
    assign o_tick_count = r_ticks;
    assign o_expiration_count = r_exps;
    assign o_last = r_ls;
endmodule

// File: hw/rtl/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker
// Port-level checks of the timer bank.
// ----------------------------------------------------------------------------
module stb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic o_expired,
    input logic o_last,
    input logic [1:0] o_run_state,
    input logic [31:0] o_expiration_count
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_last))
        else $error("stalled result changed");
    // expiration total does not move under a stalled result
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_expiration_count))
        else $error("expiration count changed while stalled");
    // expiration report is never a final result
    a_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_expired |-> !o_last)
        else $error("expiration marked last");
    // run state never takes the unused code
    a_rs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_run_state != 2'd3)
        else $error("bad run state");
endmodule

bind software_timer_bank stb_checker u_chk (.i_clk, .i_rst_n, .o_valid, .i_stall,
    .o_expired, .o_last, .o_run_state, .o_expiration_count);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the timer bank against a cycle-free model of its commands and ticks:
// directed items, then random sequences weighted to create/start/tick under varying stalls.
// ----------------------------------------------------------------------------

// Expected-result store and timer-bank model
class timer_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic        expired;
        logic [1:0]  run_state;
        logic [31:0] remaining;
        logic [31:0] tick_count;
        logic [31:0] exp_count;
        logic        last;
    } t_res;

    t_res        pending[$];
    bit          tick_en;
    bit          act[16];
    bit          per_f[16];
    logic [1:0]  run[16];
    logic [31:0] per[16];
    logic [31:0] rem[16];
    logic [31:0] ticks;
    logic [31:0] exps;
    int          errors;
    int          results_seen;

    function new();
        tick_en = 0;
        ticks = 0;
        exps = 0;
        errors = 0;
        results_seen = 0;
        for (int i = 0; i < 16; i++) begin
            act[i] = 0; per_f[i] = 0; run[i] = stb_pkg::RS_STOPPED;
            per[i] = 0; rem[i] = 0;
        end
    endfunction

    function void push(logic [1:0] st, logic [3:0] sl, logic ex, logic [1:0] rs,
                       logic [31:0] rm, logic lst);
        t_res r;
        r = '{st, sl, ex, rs, rm, ticks, exps, lst};
        pending.push_back(r);
    endfunction

    // note one accepted item and predict its results
    function void note_item(stb_pkg::t_op op, logic [3:0] sl, logic [31:0] pd, logic pf);
        int n;
        bit found;
        n = 0;
        found = 0;
        if (op == stb_pkg::OP_TICK) begin
            if (tick_en) begin
                ticks++;
                for (int i = 0; i < 16; i++) begin
                    if (act[i] && run[i] == stb_pkg::RS_RUNNING && rem[i] != 0) begin
                        rem[i]--;
                        if (rem[i] == 0) begin
                            exps++;
                            if (per_f[i]) rem[i] = per[i];
                            else run[i] = stb_pkg::RS_EXPIRED;
                            if (n < stb_pkg::MAX_REPORTS) begin
                                push(stb_pkg::ST_OK, 4'(i), 1, 0, 0, 0);
                                n++;
                            end
                        end
                    end
                end
            end
            push(stb_pkg::ST_OK, 0, 0, 0, 0, 1);
        end else if (op == stb_pkg::OP_CREATE) begin
            if (pd == 0) begin
                push(stb_pkg::ST_INVALID, 0, 0, 0, 0, 1);
            end else begin
                for (int i = 0; i < 16; i++) begin
                    if (!found && !act[i]) begin
                        found = 1;
                        act[i] = 1; per_f[i] = pf; run[i] = stb_pkg::RS_STOPPED;
                        per[i] = pd; rem[i] = pd;
                        push(stb_pkg::ST_OK, 4'(i), 0, 0, 0, 1);
                    end
                end
                if (!found) push(stb_pkg::ST_NOFREE, 0, 0, 0, 0, 1);
            end
        end else if (op == stb_pkg::OP_CHPER && pd == 0) begin
            push(stb_pkg::ST_INVALID, sl, 0, 0, 0, 1);
        end else if (!act[sl]) begin
            push(stb_pkg::ST_INACTIVE, sl, 0, 0, 0, 1);
        end else begin
            case (op)
                stb_pkg::OP_DELETE: begin
                    act[sl] = 0; run[sl] = stb_pkg::RS_STOPPED;
                end
                stb_pkg::OP_START, stb_pkg::OP_RESET: begin
                    run[sl] = stb_pkg::RS_RUNNING; rem[sl] = per[sl];
                end
                stb_pkg::OP_STOP: run[sl] = stb_pkg::RS_STOPPED;
                stb_pkg::OP_CHPER: begin
                    per[sl] = pd;
                    if (run[sl] == stb_pkg::RS_RUNNING) rem[sl] = pd;
                end
                default: ;
            endcase
            if (op == stb_pkg::OP_QUERY) push(stb_pkg::ST_OK, sl, 0, run[sl], rem[sl], 1);
            else push(stb_pkg::ST_OK, sl, 0, 0, 0, 1);
        end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(t_res got);
        t_res want;
        results_seen++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module tb_top;
    import stb_pkg::*;

    localparam int LIMIT = 2000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_op = 0;
    logic [3:0]  i_slot = 0;
    logic [31:0] i_period = 0;
    logic        i_periodic = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_status;
    logic [3:0]  o_slot_out;
    logic        o_expired;
    logic [1:0]  o_run_state;
    logic [31:0] o_remaining;
    logic [31:0] o_tick_count;
    logic [31:0] o_expiration_count;
    logic        o_last;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic        paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int cycle = 0;
    timer_scoreboard sb = new();

    software_timer_bank uut (.*);

    always #2 i_clk = ~i_clk;

    // receiver stall: random, or a long hold-off while it counts down
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result sampling
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_status, o_slot_out, o_expired, o_run_state, o_remaining,
                             o_tick_count, o_expiration_count, o_last});
    end

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // idle gaps drop valid; a back-to-back item keeps it high
    task automatic send(t_op op, logic [3:0] sl, logic [31:0] pd, logic pf);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_op <= op; i_slot <= sl; i_period <= pd; i_periodic <= pf;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(op, sl, pd, pf);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_enable(logic v);
        i_valid <= 0;
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= {31'd0, v};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.tick_en = v;
    endtask

    // mostly well-formed timer traffic with short periods
    task automatic random_item();
        int r;
        logic [31:0] pd;
        r = $urandom_range(99);
        pd = ($urandom_range(9) == 0) ? $urandom : $urandom_range(6);
        if (r < 30) send(OP_TICK, 4'($urandom), $urandom, 1'($urandom));
        else if (r < 48) send(OP_CREATE, 4'($urandom), pd, 1'($urandom));
        else if (r < 63) send(OP_START, 4'($urandom), $urandom, 1'($urandom));
        else send(t_op'($urandom_range(7)), 4'($urandom), pd, 1'($urandom));
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: disabled tick, bad parameters, inactive slots
        send(OP_TICK, 0, 0, 0);
        send(OP_CREATE, 0, 0, 1);
        send(OP_QUERY, 4'hf, 0, 0);
        send(OP_DELETE, 3, 0, 0);
        send(OP_CHPER, 2, 0, 0);
        drain();
        write_enable(1);
        send(OP_CREATE, 4'hf, 32'hffff_ffff, 1);
        send(OP_CREATE, 0, 1, 1);
        send(OP_CREATE, 0, 2, 0);
        send(OP_START, 1, 0, 0);
        send(OP_START, 2, 0, 0);
        send(OP_TICK, 0, 0, 0);
        send(OP_TICK, 0, 0, 0);
        send(OP_QUERY, 2, 0, 0);
        send(OP_STOP, 1, 0, 0);
        send(OP_RESET, 2, 0, 0);
        send(OP_CHPER, 2, 3, 0);
        send(OP_CHPER, 0, 5, 0);
        send(OP_QUERY, 0, 0, 0);
        send(OP_DELETE, 0, 0, 0);
        send(OP_QUERY, 0, 0, 0);
        for (int i = 0; i < 17; i++) send(OP_CREATE, 0, 1, 1);
        for (int i = 0; i < 16; i++) send(OP_START, 4'(i), 0, 0);
        send(OP_TICK, 0, 0, 0);
        drain();

        // random phases with varying idling; config written only while idle
        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph == 1 || ph == 3) ? 76 : 0;
            stall_pct = (ph == 2 || ph == 3) ? 76 : 0;
            if (ph == 3) begin
                idle_pct = 13; stall_pct = 13;
            end
            if (ph == 4) hold_cycles = 300;
            write_enable(ph != 1);
            for (int i = 0; i < 12; i++) send(OP_DELETE, 4'(i), 1, 0);
            for (int i = 0; i < 19; i++) random_item();
            drain();
        end
        write_enable(0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
